// ===== rtl/cmh_pkg.sv =====
// ----------------------------------------------------------------------------
// cmh_pkg: shared types and constants for the color matrix to half block
// Widths, matrix coefficients, divider constants and config codes.
// ----------------------------------------------------------------------------
package cmh_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int HALF_W          = 16;
  localparam int NUM_LANES       = 4;
  localparam int NUM_ROWS        = 3;

  // coefficient format: signed Q2.COEF_FRAC_BITS
  localparam int COEF_FRAC_BITS  = 16;
  localparam int COEF_TABLE_FRAC = 24;
  localparam int COEF_W          = COEF_FRAC_BITS + 2;

  // datapath widths
  localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = SUM_W - 1;
  // magnitude rescaled to units of 2^-COEF_TABLE_FRAC
  localparam int X_W    = MAG_W + COEF_TABLE_FRAC - COEF_FRAC_BITS;
  localparam int Q_W    = X_W;

  // depth divisors are 2^k - 1: series estimate plus small correction
  localparam int DIV8_SH  = 8;
  localparam int DIV16_SH = 16;
  localparam int DIV8     = (1 << DIV8_SH) - 1;
  localparam int DIV16    = (1 << DIV16_SH) - 1;
  localparam int N8       = (X_W - 1) / DIV8_SH;
  localparam int N16      = (X_W - 1) / DIV16_SH;
  localparam int R8_MAX   = (N8 + 1) * DIV8;
  localparam int R16_MAX  = (N16 + 1) * DIV16;
  localparam int R_W      = $clog2((R16_MAX > R8_MAX) ? R16_MAX : R8_MAX);
  localparam int CORR_W   = $clog2(((N16 > N8) ? N16 : N8) + 1);
  localparam int REM_W    = DIV16_SH;

  // binary16 packing
  localparam int MANT_W = 10;
  localparam int S_W    = $clog2(Q_W - MANT_W);
  localparam int MSB_W  = $clog2(Q_W);
  localparam int PK_W   = S_W + MANT_W + 1;
  localparam logic [HALF_W-2:0] HALF_INF = 15'h7C00;

  // pipeline layout
  localparam int MAT_STAGES  = 2;
  localparam int DIV_STAGES  = 3;
  localparam int PACK_STAGES = 3;
  localparam int STG_MAT     = 0;
  localparam int STG_DIV     = STG_MAT + MAT_STAGES;
  localparam int STG_PACK    = STG_DIV + DIV_STAGES;
  localparam int NUM_STAGES  = STG_PACK + PACK_STAGES;

  // configuration port
  localparam int DEPTH_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DEPTH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_MODE = 2'd0,
    CFG_SAMPLE_DEPTH = 2'd1
  } cfg_idx_e;

  localparam logic [DEPTH_W-1:0] DEPTH_8BIT     = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_16BIT    = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_UNSCALED = 2'd2;

  typedef struct packed {
    logic               channel_mode;
    logic [DEPTH_W-1:0] sample_depth;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic             neg;
    logic [Q_W-1:0]   quo;
    logic [REM_W-1:0] rem;
  } quot_t;

  // matrix entries times 2^24, row major
  localparam int COEF_Q24 [NUM_ROWS*NUM_ROWS] = '{
    17842118,   107340,  -264899,
    -8255779, 22955209,  1532506,
      -47206,    77845, 15376229
  };

  // table entry reduced to COEF_FRAC_BITS, rounded half away from zero
  function automatic logic signed [COEF_W-1:0] coef_used(input int idx);
    int v;
    int sh;
    int mag;
    v   = COEF_Q24[idx];
    sh  = COEF_TABLE_FRAC - COEF_FRAC_BITS;
    mag = (v < 0) ? -v : v;
    if (sh != 0) begin
      mag = (mag + (1 << (sh - 1))) >> sh;
    end
    return COEF_W'((v < 0) ? -mag : mag);
  endfunction

  localparam logic signed [COEF_W-1:0] COEF [NUM_ROWS*NUM_ROWS] = '{
    coef_used(0), coef_used(1), coef_used(2),
    coef_used(3), coef_used(4), coef_used(5),
    coef_used(6), coef_used(7), coef_used(8)
  };

endpackage

// ===== rtl/cmh_in_if.sv =====
// ----------------------------------------------------------------------------
// cmh_in_if: pixel request channel
// Valid/ready channel carrying four samples and the end-of-image flag.
// ----------------------------------------------------------------------------
interface cmh_in_if import cmh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_zero;
  logic [SAMPLE_W-1:0] sample_one;
  logic [SAMPLE_W-1:0] sample_two;
  logic [SAMPLE_W-1:0] sample_three;
  logic                image_end;

  modport source (
    output valid, sample_zero, sample_one, sample_two, sample_three, image_end,
    input  ready
  );
  modport sink (
    input  valid, sample_zero, sample_one, sample_two, sample_three, image_end,
    output ready
  );
endinterface

// ===== rtl/cmh_out_if.sv =====
// ----------------------------------------------------------------------------
// cmh_out_if: converted pixel channel
// Valid/ready channel carrying four binary16 words and the end-of-image flag.
// ----------------------------------------------------------------------------
interface cmh_out_if import cmh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] half_zero;
  logic [HALF_W-1:0] half_one;
  logic [HALF_W-1:0] half_two;
  logic [HALF_W-1:0] half_three;
  logic              image_end_out;

  modport source (
    output valid, half_zero, half_one, half_two, half_three, image_end_out,
    input  ready
  );
  modport sink (
    input  valid, half_zero, half_one, half_two, half_three, image_end_out,
    output ready
  );
endinterface

// ===== rtl/cmh_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cmh_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cmh_cfg_if import cmh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/color_matrix_to_half_core.sv =====
// ----------------------------------------------------------------------------
// color_matrix_to_half_core: color matrix with binary16 output
// Fixed 3x3 matrix on three samples, optional pass-through fourth channel,
// depth scaling and round-to-nearest-even conversion to half float.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i  carries one pixel request: three color samples, a fourth sample
//          (used in four-channel mode) and the end-of-image flag.
//   pix_o  carries the four binary16 results and the copied flag.
//   cfg_i  writes the two registers: index 0 channel mode, index 1 sample
//          depth (0: /255, 1: /65535, 2 or 3: unscaled). Always ready; write
//          only while no pixel is in flight.
//   A request passes 8 register stages (2 matrix, 3 divider, 3 packing;
//   the first loads at the accept edge). Throughput is one pixel per
//   clock while pix_o does not stall; every stage has its own valid bit.
//   Reset empties the pipeline and selects three channels, 16-bit depth.
//   When pix_o stalls, a full stage freezes only if no bubble lies ahead
//   of it, so pix_i stays ready until all 8 stages hold a pixel.
// ----------------------------------------------------------------------------
module color_matrix_to_half_core import cmh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cmh_in_if.sink    pix_i,
  cmh_out_if.source pix_o,
  cmh_cfg_if.sink   cfg_i
);

  cfg_t                  cfg_q;
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] stage_en;
  logic                  end_q  [NUM_STAGES];
  logic [SAMPLE_W-1:0]   smp    [NUM_LANES];
  lane_t                 lane   [NUM_LANES];
  quot_t                 quot   [NUM_LANES];
  logic [HALF_W-1:0]     half   [NUM_LANES];
  logic [NUM_LANES-1:0]  nan_flag;

  // ---- register writes ----
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_mode <= 1'b0;
      cfg_q.sample_depth <= DEPTH_16BIT;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_CHANNEL_MODE: cfg_q.channel_mode <= cfg_i.data[0];
        CFG_SAMPLE_DEPTH: cfg_q.sample_depth <= cfg_i.data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ---- pipeline flow control ----
  // a stage loads when it is empty or its content moves on; bubbles collapse
  always_comb begin
    stage_en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || pix_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !v_q[k] || stage_en[k+1];
    end
  end

  assign pix_i.ready = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (stage_en[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // end-of-image flag rides alongside the datapath
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      end_q[0] <= pix_i.image_end;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        end_q[k] <= end_q[k-1];
      end
    end
  end

  // ---- datapath ----
  assign smp[0] = pix_i.sample_zero;
  assign smp[1] = pix_i.sample_one;
  assign smp[2] = pix_i.sample_two;
  assign smp[3] = pix_i.sample_three;

  cmh_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (stage_en[STG_MAT +: MAT_STAGES]),
    .cfg_i  (cfg_q),
    .smp_i  (smp),
    .lane_o (lane)
  );

  // one divider and one packer per channel
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    cmh_div u_div (
      .clk_i  (clk_i),
      .en_i   (stage_en[STG_DIV +: DIV_STAGES]),
      .cfg_i  (cfg_q),
      .lane_i (lane[l]),
      .quot_o (quot[l])
    );

    cmh_pack u_pack (
      .clk_i  (clk_i),
      .en_i   (stage_en[STG_PACK +: PACK_STAGES]),
      .cfg_i  (cfg_q),
      .quot_i (quot[l]),
      .half_o (half[l])
    );
  end

  // ---- result channel ----
  assign pix_o.valid         = v_q[NUM_STAGES-1];
  assign pix_o.half_zero     = half[0];
  assign pix_o.half_one      = half[1];
  assign pix_o.half_two      = half[2];
  assign pix_o.half_three    = half[3];
  assign pix_o.image_end_out = end_q[NUM_STAGES-1];

  // ---- checks ----
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      nan_flag[l] = (half[l][HALF_W-2:MANT_W] == '1) && (half[l][MANT_W-1:0] != '0);
    end
  end

  // an accepted request always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v_q[0])
    else $error("accepted request not captured in first stage");

  // any empty stage must let a new request in
  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&v_q) |-> pix_i.ready)
    else $error("input stalled while pipeline has a free stage");

  // saturation yields infinity, never a NaN pattern
  a_no_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid |-> nan_flag == '0)
    else $error("NaN encoding on result channel");

endmodule

// ===== rtl/cmh_matrix.sv =====
// ----------------------------------------------------------------------------
// cmh_matrix: 3x3 matrix multiply, two pipeline stages
// Stage 1 registers the nine products, stage 2 the row sums as sign/magnitude.
// ----------------------------------------------------------------------------
module cmh_matrix import cmh_pkg::*; (
  input  logic                clk_i,
  input  logic [MAT_STAGES-1:0] en_i,
  input  cfg_t                cfg_i,
  input  logic [SAMPLE_W-1:0] smp_i  [NUM_LANES],
  output lane_t               lane_o [NUM_LANES]
);

  logic signed [PROD_W-1:0] prod_d [NUM_ROWS][NUM_ROWS];
  logic signed [PROD_W-1:0] prod_q [NUM_ROWS][NUM_ROWS];
  logic [SAMPLE_W-1:0]      s3_q;
  lane_t                    lane_d [NUM_LANES];
  lane_t                    lane_q [NUM_LANES];

  // constant multipliers, operands widened so the product is exact
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        prod_d[r][c] = $signed(PROD_W'(smp_i[c])) * PROD_W'(COEF[r*NUM_ROWS+c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      s3_q   <= smp_i[NUM_ROWS];
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
      lane_d[r].neg = sum[SUM_W-1];
      lane_d[r].mag = MAG_W'(sum[SUM_W-1] ? -sum : sum);
    end
    // fourth channel: unity gain, zero in three-channel mode
    lane_d[NUM_ROWS].neg = 1'b0;
    lane_d[NUM_ROWS].mag = cfg_i.channel_mode ?
                           MAG_W'({s3_q, {COEF_FRAC_BITS{1'b0}}}) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/cmh_div.sv =====
// ----------------------------------------------------------------------------
// cmh_div: division by the depth divisor, three pipeline stages
// Series estimate of x/(2^k-1), remainder-based correction, final add.
// ----------------------------------------------------------------------------
module cmh_div import cmh_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  cfg_t                  cfg_i,
  input  lane_t                 lane_i,
  output quot_t                 quot_o
);

  logic [X_W-1:0]    x;
  logic [Q_W-1:0]    est_d;
  logic [Q_W-1:0]    est_q;
  logic [R_W-1:0]    xlo_q;
  logic              neg_a_q;

  logic [CORR_W-1:0] corr_d;
  logic [REM_W-1:0]  rem_d;
  logic [Q_W-1:0]    est_b_q;
  logic [CORR_W-1:0] corr_q;
  logic [REM_W-1:0]  rem_q;
  logic              neg_b_q;

  quot_t             quot_q;

  assign x = {lane_i.mag, {(COEF_TABLE_FRAC-COEF_FRAC_BITS){1'b0}}};

  // x/(2^k-1) = sum of x >> jk; truncation leaves it a few units low
  always_comb begin
    logic [Q_W-1:0] e8;
    logic [Q_W-1:0] e16;
    e8  = '0;
    e16 = '0;
    for (int j = 1; j <= N8; j++) begin
      e8 = e8 + (x >> (j * DIV8_SH));
    end
    for (int j = 1; j <= N16; j++) begin
      e16 = e16 + (x >> (j * DIV16_SH));
    end
    case (cfg_i.sample_depth)
      DEPTH_8BIT:  est_d = e8;
      DEPTH_16BIT: est_d = e16;
      default:     est_d = x;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      est_q   <= est_d;
      xlo_q   <= x[R_W-1:0];
      neg_a_q <= lane_i.neg;
    end
  end

  // remainder is small, so only the low bits are needed
  always_comb begin
    logic [R_W-1:0]    elo;
    logic [R_W-1:0]    r8;
    logic [R_W-1:0]    r16;
    logic [CORR_W-1:0] c8;
    logic [CORR_W-1:0] c16;
    elo = est_q[R_W-1:0];
    r8  = xlo_q - (elo << DIV8_SH) + elo;
    r16 = xlo_q - (elo << DIV16_SH) + elo;
    c8  = '0;
    c16 = '0;
    for (int k = 1; k <= N8; k++) begin
      if (r8 >= R_W'(k * DIV8)) begin
        c8 = c8 + CORR_W'(1);
      end
    end
    for (int k = 1; k <= N16; k++) begin
      if (r16 >= R_W'(k * DIV16)) begin
        c16 = c16 + CORR_W'(1);
      end
    end
    case (cfg_i.sample_depth)
      DEPTH_8BIT: begin
        corr_d = c8;
        rem_d  = REM_W'(r8 - R_W'(c8) * R_W'(DIV8));
      end
      DEPTH_16BIT: begin
        corr_d = c16;
        rem_d  = REM_W'(r16 - R_W'(c16) * R_W'(DIV16));
      end
      default: begin
        corr_d = '0;
        rem_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      est_b_q <= est_q;
      corr_q  <= corr_d;
      rem_q   <= rem_d;
      neg_b_q <= neg_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      quot_q.quo <= est_b_q + Q_W'(corr_q);
      quot_q.rem <= rem_q;
      quot_q.neg <= neg_b_q;
    end
  end

  assign quot_o = quot_q;

endmodule

// ===== rtl/cmh_pack.sv =====
// ----------------------------------------------------------------------------
// cmh_pack: quotient to binary16, three pipeline stages
// Leading-one search, mantissa extract with guard/sticky, round and saturate.
// ----------------------------------------------------------------------------
module cmh_pack import cmh_pkg::*; (
  input  logic                   clk_i,
  input  logic [PACK_STAGES-1:0] en_i,
  input  cfg_t                   cfg_i,
  input  quot_t                  quot_i,
  output logic [HALF_W-1:0]      half_o
);

  logic [S_W-1:0]    s_d;
  logic [S_W-1:0]    s_q;
  quot_t             quot_q;

  logic [MANT_W:0]   mant_d;
  logic              guard_d;
  logic              sticky_d;
  logic [MANT_W:0]   mant_q;
  logic [S_W-1:0]    s_b_q;
  logic              guard_q;
  logic              sticky_q;
  logic              neg_b_q;

  logic [HALF_W-1:0] half_d;
  logic [HALF_W-1:0] half_q;

  // shift needed to bring the quotient below 2^(MANT_W+1)
  always_comb begin
    logic [MSB_W-1:0] msb;
    msb = '0;
    for (int i = 0; i < Q_W; i++) begin
      if (quot_i.quo[i]) begin
        msb = MSB_W'(i);
      end
    end
    s_d = (msb > MSB_W'(MANT_W)) ? S_W'(msb - MSB_W'(MANT_W)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s_q    <= s_d;
      quot_q <= quot_i;
    end
  end

  // with no shift the round bit comes from the division remainder
  always_comb begin
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    gmask;
    logic [REM_W:0]    div;
    mant_d = (MANT_W+1)'(quot_q.quo >> s_q);
    low    = quot_q.quo & ~({Q_W{1'b1}} << s_q);
    gmask  = Q_W'(1) << (s_q - S_W'(1));
    case (cfg_i.sample_depth)
      DEPTH_8BIT:  div = (REM_W+1)'(DIV8);
      DEPTH_16BIT: div = (REM_W+1)'(DIV16);
      default:     div = (REM_W+1)'(1);
    endcase
    if (s_q == '0) begin
      guard_d  = {quot_q.rem, 1'b0} > div;
      sticky_d = quot_q.rem != '0;
    end else begin
      guard_d  = |(low & gmask);
      sticky_d = (|(low & ~gmask)) || (quot_q.rem != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mant_q   <= mant_d;
      s_b_q    <= s_q;
      guard_q  <= guard_d;
      sticky_q <= sticky_d;
      neg_b_q  <= quot_q.neg;
    end
  end

  // nearest even; a mantissa carry rolls into the exponent field
  always_comb begin
    logic            up;
    logic [MANT_W+1:0] mant_r;
    logic [PK_W-1:0] bits;
    up     = guard_q && (sticky_q || mant_q[0]);
    mant_r = (MANT_W+2)'(mant_q) + (MANT_W+2)'(up);
    bits   = (PK_W'(s_b_q) << MANT_W) + PK_W'(mant_r);
    if (bits > PK_W'(HALF_INF)) begin
      half_d = {neg_b_q, HALF_INF};
    end else begin
      half_d = {neg_b_q, bits[HALF_W-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      half_q <= half_d;
    end
  end

  assign half_o = half_q;

endmodule

// ===== bench/cmh_checker.sv =====
// ----------------------------------------------------------------------------
// cmh_checker: result predictor and scoreboard for color_matrix_to_half_core
// Mirrors the two registers from the write channel. For every pixel request
// it computes the four binary16 words and queues them. Each converted pixel is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module cmh_checker import cmh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cmh_in_if    pix_i,
  cmh_out_if   pix_o,
  cmh_cfg_if   cfg_i,
  output int   mismatch_cnt,
  output int   pending_cnt
);

  localparam int PRINT_CAP = 200;
  localparam longint unsigned DIV_8BIT  = 255;
  localparam longint unsigned DIV_16BIT = 65535;

  // matrix entries scaled by 2^24, row major
  localparam longint MATRIX_Q24 [9] = '{
    17842118,   107340,  -264899,
    -8255779, 22955209,  1532506,
      -47206,    77845, 15376229
  };

  typedef struct packed {
    logic [HALF_W-1:0] h0;
    logic [HALF_W-1:0] h1;
    logic [HALF_W-1:0] h2;
    logic [HALF_W-1:0] h3;
    logic              eoi;
  } half_pix_t;

  half_pix_t          halves_due [$];
  half_pix_t          want;
  logic               mode_q;
  logic [DEPTH_W-1:0] depth_q;

  // table entry cut down to COEF_FRAC_BITS, ties away from zero
  function automatic longint matrix_coef(input int k);
    longint v;
    longint m;
    int     sh;
    v  = MATRIX_Q24[k];
    sh = COEF_TABLE_FRAC - COEF_FRAC_BITS;
    m  = (v < 0) ? -v : v;
    if (sh > 0) begin
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    return (v < 0) ? -m : m;
  endfunction

  // mag / (div * 2^COEF_FRAC_BITS) to binary16, nearest even, saturate to inf
  function automatic logic [HALF_W-1:0] round_to_half(input bit neg,
                                                       input longint unsigned mag,
                                                       input longint unsigned div);
    longint unsigned x;
    longint unsigned q;
    longint unsigned t;
    longint unsigned mant;
    longint unsigned resid;
    longint unsigned unit;
    longint unsigned bits;
    int              s;
    x = mag << (COEF_TABLE_FRAC - COEF_FRAC_BITS);
    q = x / div;
    t = q;
    s = 0;
    while ((t >> 11) != 0) begin
      t = t >> 1;
      s++;
    end
    mant  = q >> s;
    resid = x - ((mant << s) * div);
    unit  = (64'd1 << s) * div;
    if ((2 * resid > unit) || ((2 * resid == unit) && ((mant & 64'd1) != 0))) begin
      mant++;
    end
    bits = (longint'(s) << 10) + mant;
    if (bits > 64'h7C00) begin
      bits = 64'h7C00;
    end
    if (neg) begin
      bits = bits | 64'h8000;
    end
    return bits[HALF_W-1:0];
  endfunction

  function automatic half_pix_t convert_pixel(input logic               mode,
                                              input logic [DEPTH_W-1:0] depth,
                                              input logic [SAMPLE_W-1:0] s0,
                                              input logic [SAMPLE_W-1:0] s1,
                                              input logic [SAMPLE_W-1:0] s2,
                                              input logic [SAMPLE_W-1:0] s3,
                                              input logic               eoi);
    longint unsigned   div;
    longint            smp [3];
    longint            acc;
    logic [HALF_W-1:0] row [3];
    half_pix_t         r;
    case (depth)
      DEPTH_8BIT:  div = DIV_8BIT;
      DEPTH_16BIT: div = DIV_16BIT;
      default:     div = 1;
    endcase
    smp[0] = longint'(s0);
    smp[1] = longint'(s1);
    smp[2] = longint'(s2);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc = acc + matrix_coef(i * 3 + j) * smp[j];
      end
      if (acc < 0) begin
        row[i] = round_to_half(1'b1, longint'(-acc), div);
      end else begin
        row[i] = round_to_half(1'b0, longint'(acc), div);
      end
    end
    r.h0  = row[0];
    r.h1  = row[1];
    r.h2  = row[2];
    // fourth lane passes through with coefficient one
    r.h3  = mode ? round_to_half(1'b0, longint'(s3) << COEF_FRAC_BITS, div) : '0;
    r.eoi = eoi;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP) begin
      $display("%0t cmh_checker: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [HALF_W-1:0] got,
                               input logic [HALF_W-1:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %h, predicted %h", name, got, exp_val));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  = 1'b0;
      depth_q = DEPTH_16BIT;
      halves_due.delete();
      pending_cnt <= 0;
    end else begin
      if (pix_o.valid && pix_o.ready) begin
        if (halves_due.size() == 0) begin
          report_mismatch($sformatf("converted pixel %h %h %h %h with no request due",
                                    pix_o.half_zero, pix_o.half_one,
                                    pix_o.half_two, pix_o.half_three));
        end else begin
          want = halves_due.pop_front();
          compare_field("half_zero", pix_o.half_zero, want.h0);
          compare_field("half_one", pix_o.half_one, want.h1);
          compare_field("half_two", pix_o.half_two, want.h2);
          compare_field("half_three", pix_o.half_three, want.h3);
          compare_field("image_end_out", HALF_W'(pix_o.image_end_out), HALF_W'(want.eoi));
        end
      end
      // prediction uses the registers as they stand before any write this edge
      if (pix_i.valid && pix_i.ready) begin
        halves_due.insert(halves_due.size(),
                          convert_pixel(mode_q, depth_q, pix_i.sample_zero,
                                        pix_i.sample_one, pix_i.sample_two,
                                        pix_i.sample_three, pix_i.image_end));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_CHANNEL_MODE: mode_q = cfg_i.data[0];
          CFG_SAMPLE_DEPTH: depth_q = cfg_i.data;
          default: ;
        endcase
      end
      pending_cnt <= halves_due.size();
    end
  end

endmodule

// ===== bench/color_matrix_to_half_core_tb.sv =====
// ----------------------------------------------------------------------------
// color_matrix_to_half_core_tb: stimulus and verdict for the color matrix core
// Drives pixel requests and register writes, stalls the result side at random,
// and leaves prediction and comparison to cmh_checker.
// ----------------------------------------------------------------------------
module color_matrix_to_half_core_tb;
  import cmh_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 8;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake anywhere
  localparam int HOLD_CYCLES  = 64;    // long result-side stall
  localparam int TAIL_CYCLES  = 16;    // settle time before the verdict
  localparam int IDLE_PCT     = 33;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 115;
  localparam int BURST_ITEMS  = 40;
  localparam int FLOOD_PHASE  = 2;     // neither side idles
  localparam int HOLD_PHASE   = 3;     // receiver holds off, sender floods a burst

  // write data values for the channel mode register
  localparam logic [CFG_DATA_W-1:0] MODE_THREE  = 2'd0;
  localparam logic [CFG_DATA_W-1:0] MODE_FOUR   = 2'd1;
  localparam logic [CFG_DATA_W-1:0] MODE_MASKED = 2'd2;  // bit 0 clear: three
  // depth code 3 behaves as unscaled
  localparam logic [DEPTH_W-1:0]    DEPTH_ALIAS = 2'd3;
  // indexes past the two registers, to be ignored
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_HI = 2'd3;

  localparam logic [CFG_DATA_W-1:0] PHASE_MODE [NUM_PHASES] = '{
    MODE_FOUR, MODE_THREE, MODE_FOUR, MODE_THREE, MODE_FOUR, MODE_FOUR
  };
  localparam logic [DEPTH_W-1:0] PHASE_DEPTH [NUM_PHASES] = '{
    DEPTH_16BIT, DEPTH_8BIT, DEPTH_UNSCALED, DEPTH_16BIT, DEPTH_8BIT, DEPTH_ALIAS
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  // idle switches, one writer each (the stimulus process)
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_asks  = 0;

  int mismatch_cnt;
  int pending_cnt;

  cmh_in_if  pix_if ();
  cmh_out_if res_if ();
  cmh_cfg_if cfg_if ();

  color_matrix_to_half_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .pix_o  (res_if),
    .cfg_i  (cfg_if)
  );

  cmh_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_if),
    .pix_o        (res_if),
    .cfg_i        (cfg_if),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Offer one pixel request. Random idle cycles go in front of it; valid is
  // only lowered during a gap, so back-to-back requests keep it high.
  task automatic send_pixel(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
                            input logic [SAMPLE_W-1:0] s2, input logic [SAMPLE_W-1:0] s3,
                            input logic eoi);
    if (tx_idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        pix_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    pix_if.valid        <= 1'b1;
    pix_if.sample_zero  <= s0;
    pix_if.sample_one   <= s1;
    pix_if.sample_two   <= s2;
    pix_if.sample_three <= s3;
    pix_if.image_end    <= eoi;
    @(posedge clk_i);
    while (!pix_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted pixel has come out. The first
  // edge lets the checker count a request taken at the current edge.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Register write; keep_valid leaves valid up for a write that follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input bit keep_valid);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) begin
      @(posedge clk_i);
    end
    if (!keep_valid) begin
      cfg_if.valid <= 1'b0;
    end
  endtask

  // Sample mix: edges, 8-bit range, 12-bit range, near full scale and full random
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(255));
      3:       return SAMPLE_W'($urandom_range(4095));
      4:       return SAMPLE_W'(16'hFFFF - $urandom_range(255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_seen) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_seen = hold_asks;
      end else begin
        res_if.ready <= !(rx_idle_on && ($urandom_range(99) < IDLE_PCT));
      end
    end
  end

  // Watchdog: a run that stops moving fails
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("color_matrix_to_half_core_tb: errors");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    pix_if.valid        <= 1'b0;
    pix_if.sample_zero  <= '0;
    pix_if.sample_one   <= '0;
    pix_if.sample_two   <= '0;
    pix_if.sample_three <= '0;
    pix_if.image_end    <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_CHANNEL_MODE;
    cfg_if.data         <= '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: reset settings, three channels at 16-bit depth ----
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    // fourth sample must be ignored, half_three stays zero
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // second row negative
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);  // first row negative
    // third row cancels to a tiny negative value, rounds to negative zero
    send_pixel(16'h0002, 16'h0001, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    send_pixel(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0);
    wait_drained();

    // ---- four channels, 8-bit depth, samples above 255 are not clipped ----
    write_reg(CFG_CHANNEL_MODE, MODE_FOUR, 1'b1);
    write_reg(CFG_SAMPLE_DEPTH, DEPTH_8BIT, 1'b0);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b0);
    send_pixel(16'h0080, 16'h0040, 16'h0020, 16'h00FF, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'h012C, 16'h0000, 16'h03E8, 16'h0100, 1'b0);
    wait_drained();

    // ---- unscaled: first row and fourth lane overflow to infinity ----
    write_reg(CFG_SAMPLE_DEPTH, DEPTH_UNSCALED, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_pixel(16'hFFE0, 16'h8000, 16'h7FFF, 16'hFFE0, 1'b1);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    wait_drained();

    // ---- depth code 3 acts as unscaled ----
    write_reg(CFG_SAMPLE_DEPTH, DEPTH_ALIAS, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0);
    wait_drained();

    // ---- data masked to one bit, writes past the last index dropped ----
    write_reg(CFG_CHANNEL_MODE, MODE_MASKED, 1'b1);
    write_reg(CFG_SPARE_LO, DEPTH_8BIT, 1'b1);
    write_reg(CFG_SPARE_HI, DEPTH_16BIT, 1'b0);
    send_pixel(16'hFFFF, 16'h1234, 16'hABCD, 16'hFFFF, 1'b0);
    send_pixel(16'h00FF, 16'h0000, 16'hFFFF, 16'h5555, 1'b1);
    wait_drained();

    // ---- random phases, one register setting each ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_CHANNEL_MODE, PHASE_MODE[ph], 1'b1);
      write_reg(CFG_SAMPLE_DEPTH, PHASE_DEPTH[ph], 1'b0);
      rx_idle_on = (ph != FLOOD_PHASE);
      if (ph == HOLD_PHASE) begin
        // receiver freezes while the sender keeps offering: pipeline fills
        hold_asks++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        tx_idle_on = !((ph == FLOOD_PHASE) || ((ph == HOLD_PHASE) && (i < BURST_ITEMS)));
        send_pixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                   ($urandom_range(15) == 0));
      end
      // sender pauses until every result is back before the next write
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("color_matrix_to_half_core_tb: clean");
    end else begin
      $display("color_matrix_to_half_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cmh_pkg.sv
rtl/cmh_in_if.sv
rtl/cmh_out_if.sv
rtl/cmh_cfg_if.sv
rtl/cmh_matrix.sv
rtl/cmh_div.sv
rtl/cmh_pack.sv
rtl/color_matrix_to_half_core.sv
bench/cmh_checker.sv
bench/color_matrix_to_half_core_tb.sv
